// ===== src/lkvc_pkg.sv =====
// Package: sizes, codes, state and command types of the LRU key-value cache.
`default_nettype none

package lkvc_pkg;

    localparam int ENTRIES = 16;
    localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W   = $clog2(ENTRIES + 1);
    localparam int CAP_W   = 5;
    localparam int CMP_W   = (CAP_W > CNT_W) ? CAP_W : CNT_W;
    localparam int DATA_W  = 32;

    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'((ENTRIES > 31) ? 31 : ENTRIES);
    localparam logic signed [DATA_W-1:0] MISS_VALUE = -DATA_W'(1);
    localparam logic signed [DATA_W-1:0] PUT_VALUE  = '0;

    typedef enum logic
    {
        MODE_GET = 1'b0,
        MODE_PUT = 1'b1
    } lkvc_mode_t;

    typedef enum logic [2:0]
    {
        ST_IDLE,
        ST_MATCH,
        ST_EXEC,
        ST_EVICT,
        ST_INSERT
    } lkvc_state_t;

    typedef struct packed
    {
        logic latch;
        logic match;
        logic promote;
        logic write_val;
        logic evict;
        logic insert;
        logic load_out;
    } lkvc_cmd_t;

    typedef struct packed
    {
        logic mode;
        logic hit;
        logic full;
        logic out_free;
    } lkvc_sts_t;

endpackage

`default_nettype wire

// ===== src/lkvc_if.sv =====
// Interfaces: request and response channels of the LRU key-value cache.
`default_nettype none

interface lkvc_req_if;
    logic                      valid;
    logic                      ready;
    logic                      mode;
    logic signed [31:0]        lookup_key;
    logic signed [31:0]        store_value;

    modport source (output valid, mode, lookup_key, store_value, input ready);
    modport sink   (input valid, mode, lookup_key, store_value, output ready);
endinterface

interface lkvc_rsp_if;
    logic                      valid;
    logic                      ready;
    logic                      hit;
    logic signed [31:0]        read_value;

    modport source (output valid, hit, read_value, input ready);
    modport sink   (input valid, hit, read_value, output ready);
endinterface

`default_nettype wire

// ===== src/lkvc_ctrl.sv =====
// Controller: sequences match, update, eviction, insertion and response load.
`default_nettype none

module lkvc_ctrl
    import lkvc_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      req_valid,
    output logic           req_ready,
    input  wire lkvc_sts_t sts,
    output lkvc_cmd_t      cmd
);

    lkvc_state_t state_reg;
    lkvc_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        req_ready  = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.latch  = 1'b1;
                    state_next = ST_MATCH;
                end
            end
            ST_MATCH:
            begin
                cmd.match  = 1'b1;
                state_next = ST_EXEC;
            end
            ST_EXEC:
            begin
                if (sts.mode == MODE_PUT && !sts.hit)
                begin
                    state_next = sts.full ? ST_EVICT : ST_INSERT;
                end
                else if (sts.out_free)
                begin
                    cmd.load_out  = 1'b1;
                    cmd.promote   = (sts.mode == MODE_GET) && sts.hit;
                    cmd.write_val = (sts.mode == MODE_PUT) && sts.hit;
                    state_next    = ST_IDLE;
                end
            end
            ST_EVICT:
            begin
                cmd.evict  = 1'b1;
                state_next = ST_INSERT;
            end
            ST_INSERT:
            begin
                if (sts.out_free)
                begin
                    cmd.insert   = 1'b1;
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== src/lkvc_datapath.sv =====
// Datapath: entry store, tag match, recency ranks, occupancy and response register.
`default_nettype none

module lkvc_datapath
    import lkvc_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     cfg_we,
    input  wire logic [CAP_W-1:0]         cfg_wdata,
    input  wire logic                     in_mode,
    input  wire logic signed [DATA_W-1:0] in_key,
    input  wire logic signed [DATA_W-1:0] in_value,
    input  wire lkvc_cmd_t                cmd,
    output lkvc_sts_t                     sts,
    output logic                          out_valid,
    input  wire logic                     out_ready,
    output logic                          out_hit,
    output logic signed [DATA_W-1:0]      out_value
);

    logic                     req_mode_reg;
    logic signed [DATA_W-1:0] req_key_reg;
    logic signed [DATA_W-1:0] req_value_reg;
    logic                     hit_reg;
    logic [IDX_W-1:0]         slot_reg;

    logic [ENTRIES-1:0]       valid_reg;
    logic signed [DATA_W-1:0] key_reg [ENTRIES];
    logic signed [DATA_W-1:0] val_reg [ENTRIES];
    logic [IDX_W-1:0]         rank_reg [ENTRIES];
    logic [CNT_W-1:0]         occ_reg;
    logic [CAP_W-1:0]         cap_reg;

    logic                     out_valid_reg;
    logic                     out_hit_reg;
    logic signed [DATA_W-1:0] out_value_reg;

    logic [ENTRIES-1:0]       match_vec;
    logic [IDX_W-1:0]         match_slot;
    logic [IDX_W-1:0]         victim_slot;
    logic [IDX_W-1:0]         free_slot;
    logic [CNT_W-1:0]         last_rank;
    logic [CMP_W-1:0]         eff_cap;
    logic                     out_free;

    always_comb
    begin
        match_slot = '0;
        free_slot  = '0;
        for (int i = ENTRIES - 1; i >= 0; i--)
        begin
            match_vec[i] = valid_reg[i] && (key_reg[i] == req_key_reg);
            if (match_vec[i])
            begin
                match_slot = IDX_W'(i);
            end
            if (!valid_reg[i])
            begin
                free_slot = IDX_W'(i);
            end
        end
    end

    assign last_rank = occ_reg - CNT_W'(1);

    always_comb
    begin
        victim_slot = '0;
        for (int i = 0; i < ENTRIES; i++)
        begin
            if (valid_reg[i] && (CNT_W'(rank_reg[i]) == last_rank))
            begin
                victim_slot = IDX_W'(i);
            end
        end
    end

    always_comb
    begin
        if (cap_reg == '0)
        begin
            eff_cap = CMP_W'(1);
        end
        else if (int'(cap_reg) > ENTRIES)
        begin
            eff_cap = CMP_W'(ENTRIES);
        end
        else
        begin
            eff_cap = CMP_W'(cap_reg);
        end
    end

    assign out_free     = !out_valid_reg || out_ready;
    assign sts.mode     = req_mode_reg;
    assign sts.hit      = hit_reg;
    assign sts.full     = CMP_W'(occ_reg) >= eff_cap;
    assign sts.out_free = out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg <= CAP_RESET;
        end
        else if (cfg_we)
        begin
            cap_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            req_mode_reg  <= in_mode;
            req_key_reg   <= in_key;
            req_value_reg <= in_value;
        end
        if (cmd.match)
        begin
            hit_reg  <= |match_vec;
            slot_reg <= match_slot;
        end
        if (cmd.write_val)
        begin
            val_reg[slot_reg] <= req_value_reg;
        end
        if (cmd.insert)
        begin
            key_reg[free_slot] <= req_key_reg;
            val_reg[free_slot] <= req_value_reg;
        end
        if (cmd.load_out)
        begin
            if (req_mode_reg == MODE_PUT)
            begin
                out_hit_reg   <= 1'b1;
                out_value_reg <= PUT_VALUE;
            end
            else if (hit_reg)
            begin
                out_hit_reg   <= 1'b1;
                out_value_reg <= val_reg[slot_reg];
            end
            else
            begin
                out_hit_reg   <= 1'b0;
                out_value_reg <= MISS_VALUE;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            occ_reg   <= '0;
            for (int i = 0; i < ENTRIES; i++)
            begin
                rank_reg[i] <= '0;
            end
        end
        else
        begin
            if (cmd.promote)
            begin
                for (int i = 0; i < ENTRIES; i++)
                begin
                    if (valid_reg[i] && (rank_reg[i] < rank_reg[slot_reg]))
                    begin
                        rank_reg[i] <= rank_reg[i] + IDX_W'(1);
                    end
                end
                rank_reg[slot_reg] <= '0;
            end
            if (cmd.evict && (occ_reg != '0))
            begin
                valid_reg[victim_slot] <= 1'b0;
                occ_reg                <= occ_reg - CNT_W'(1);
            end
            if (cmd.insert && !(&valid_reg))
            begin
                for (int i = 0; i < ENTRIES; i++)
                begin
                    if (valid_reg[i])
                    begin
                        rank_reg[i] <= rank_reg[i] + IDX_W'(1);
                    end
                end
                rank_reg[free_slot]  <= '0;
                valid_reg[free_slot] <= 1'b1;
                occ_reg              <= occ_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_hit   = out_hit_reg;
    assign out_value = out_value_reg;

    a_occ_matches_valid: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(valid_reg) == int'(occ_reg))
        else $error("occupancy disagrees with valid entries");

    a_evict_drops_one: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.evict |=> (occ_reg == $past(occ_reg) - CNT_W'(1)))
        else $error("eviction did not drop one entry");

    a_insert_adds_one: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.insert |=> (occ_reg == $past(occ_reg) + CNT_W'(1)))
        else $error("insertion did not add one entry");

    a_load_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> out_free)
        else $error("response loaded over an untaken item");

endmodule

`default_nettype wire

// ===== src/lru_key_value_cache.sv =====
// Top level: LRU key-value cache, controller and datapath.
//
//  channel | dir | handshake   | payload
//  req     | in  | valid/ready | mode, lookup_key, store_value
//  rsp     | out | valid/ready | hit, read_value
//  cfg     | in  | cfg_we      | cfg_wdata (capacity)
//
// Get, or put to a present key: steps are accept, registered tag match, update.
// Put to a new key: accept, match, decide, insert; the victim is evicted first when
// occupancy has reached capacity.
// Reset clears all entries at once; no clearing pass.
// A stalled rsp holds the finished item; the next req is taken meanwhile and waits
// at its final step until the response register frees.
`default_nettype none

module lru_key_value_cache
    import lkvc_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             cfg_we,
    input  wire logic [CAP_W-1:0] cfg_wdata,
    lkvc_req_if.sink              req,
    lkvc_rsp_if.source            rsp
);

    lkvc_cmd_t cmd;
    lkvc_sts_t sts;
    logic      ready_w;

    assign req.ready = ready_w;

    lkvc_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (ready_w),
        .sts       (sts),
        .cmd       (cmd)
    );

    lkvc_datapath u_datapath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_mode   (req.mode),
        .in_key    (req.lookup_key),
        .in_value  (req.store_value),
        .cmd       (cmd),
        .sts       (sts),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .out_hit   (rsp.hit),
        .out_value (rsp.read_value)
    );

endmodule

`default_nettype wire
